>>> hw/rtl/vlrq_pkg.sv
// ----------------------------------------------------------------------------
// vlrq_pkg: shared types and constants for the variable-length record queue
// Field widths, status codes, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package vlrq_pkg;

   // default sizing handed to the top-level parameters
   localparam int DEF_MAX_SLOTS      = 64;
   localparam int DEF_MAX_DATA_BYTES = 65536;

   // fixed word field widths
   localparam int LEN_W      = 17;   // record length / data_bytes register
   localparam int TOT_W      = LEN_W + 1; // front + body before range check
   localparam int OFF_OUT_W  = 16;   // reported entry offset
   localparam int STATUS_W   = 3;
   localparam int SC_REG_W   = 7;    // slot_count register width

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;
   localparam logic [CSR_IDX_W-1:0] REG_SLOT_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DATA_BYTES = 2'd1;

   // request modes
   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_RING_FULL = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd4;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP,
      ST_WALK
   } vlrq_state_type;

endpackage

`default_nettype wire

>>> hw/rtl/variable_length_record_queue.sv
// Sequence: an empty pop or a failed size or full check answers from ST_EXEC,
//   a pop from ST_POP after the descriptor read, and a push from ST_WALK once the
//   queued records are walked (one RAM read a cycle; a clash ends the walk early).
// Throughput: one word at a time; busy drops in the strobe cycle, so start is
//   taken again at the edge that takes the response. The walk sets the push rate.
// Reset (synchronous): queue empty, indexes and write offset zero, slot_count =
//   min(MAX_SLOTS, 64), data_bytes = min(MAX_DATA_BYTES, 65536); no receiver stall.
// ----------------------------------------------------------------------------
// variable_length_record_queue: descriptor ring plus byte data ring
// Allocates variable-length records in a data area and tracks them in a ring
// of descriptors; a push checks for overlap by walking the queued entries.
// ----------------------------------------------------------------------------
`default_nettype none

module variable_length_record_queue
   import vlrq_pkg::*;
#(
   parameter int MAX_SLOTS      = DEF_MAX_SLOTS,
   parameter int MAX_DATA_BYTES = DEF_MAX_DATA_BYTES
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // command channel
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_mode,
   input  wire logic [LEN_W-1:0]      req_front_length,
   input  wire logic [LEN_W-1:0]      req_body_length,
   // response channel
   output logic                       rsp_valid,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [OFF_OUT_W-1:0]       rsp_entry_offset,
   output logic [LEN_W-1:0]           rsp_entry_length,
   // configuration writes
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // derived sizing
   localparam int SW     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CW     = $clog2(MAX_SLOTS + 1);
   localparam int DB_CAP = (MAX_DATA_BYTES < 131071) ? MAX_DATA_BYTES : 131071;
   localparam int OW     = $clog2(DB_CAP + 1);
   localparam int SC_RST = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;
   localparam int DB_RST = (MAX_DATA_BYTES < 65536) ? MAX_DATA_BYTES : 65536;
   localparam int RAM_W  = OW + LEN_W;

   vlrq_state_type        state_ff, state_in;
   logic                  mode_ff, mode_in;
   logic [TOT_W-1:0]      tot_ff, tot_in;
   logic [CW-1:0]         slot_count_ff, slot_count_in;
   logic [OW-1:0]         data_bytes_ff, data_bytes_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [SW-1:0]         push_idx_ff, push_idx_in;
   logic [SW-1:0]         pop_idx_ff, pop_idx_in;
   logic [OW-1:0]         wo_ff, wo_in;
   logic [SW-1:0]         walk_idx_ff, walk_idx_in;
   logic [CW-1:0]         walk_left_ff, walk_left_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [OFF_OUT_W-1:0]  rsp_offset_ff, rsp_offset_in;
   logic [LEN_W-1:0]      rsp_length_ff, rsp_length_in;

   logic                  ram_wr_en;
   logic [SW-1:0]         ram_rd_addr;
   logic [RAM_W-1:0]      ram_wr_data;
   logic [RAM_W-1:0]      ram_rd_data;
   logic [OW-1:0]         rd_start;
   logic [LEN_W-1:0]      rd_size;
   logic [OW-1:0]         start_dist;
   logic                  walk_hit;
   logic                  need_wrap;
   logic [SC_REG_W-1:0]   sc_wr;
   logic [LEN_W-1:0]      db_wr;

   // next slot index modulo slot_count
   function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] idx);
      logic [CW:0] n;
      n = {{(CW + 1 - SW){1'b0}}, idx} + 1'b1;
      return (n >= {1'b0, slot_count_ff}) ? '0 : n[SW-1:0];
   endfunction

   // byte offset narrowed to the reported width
   function automatic logic [OFF_OUT_W-1:0] off_out(input logic [OW-1:0] off);
      logic [TOT_W-1:0] t;
      t = TOT_W'(off);
      return t[OFF_OUT_W-1:0];
   endfunction

   // descriptor store: start offset and record size
   vlrq_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_SLOTS),
      .AW    (SW)
   ) u_desc_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (push_idx_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // unpack descriptor and run the shared overlap compare
   assign rd_start    = ram_rd_data[RAM_W-1 -: OW];
   assign rd_size     = ram_rd_data[LEN_W-1:0];
   assign start_dist  = rd_start - wo_ff;
   assign walk_hit    = (rd_start >= wo_ff) && (TOT_W'(start_dist) < tot_ff);
   assign need_wrap   = (wo_ff > data_bytes_ff) ||
                        (tot_ff > (TOT_W'(data_bytes_ff) - TOT_W'(wo_ff)));
   assign ram_wr_data = {wo_ff, tot_ff[LEN_W-1:0]};
   assign sc_wr       = csr_wdata[SC_REG_W-1:0];
   assign db_wr       = csr_wdata[LEN_W-1:0];

   // state register and bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_count_ff <= CW'(SC_RST);
         data_bytes_ff <= OW'(DB_RST);
         count_ff      <= '0;
         push_idx_ff   <= '0;
         pop_idx_ff    <= '0;
         wo_ff         <= '0;
         walk_left_ff  <= '0;
         chk_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_count_ff <= slot_count_in;
         data_bytes_ff <= data_bytes_in;
         count_ff      <= count_in;
         push_idx_ff   <= push_idx_in;
         pop_idx_ff    <= pop_idx_in;
         wo_ff         <= wo_in;
         walk_left_ff  <= walk_left_in;
         chk_vld_ff    <= chk_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      tot_ff        <= tot_in;
      walk_idx_ff   <= walk_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_length_ff <= rsp_length_in;
   end

   // sequencer: next state, RAM control and response
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      tot_in        = tot_ff;
      slot_count_in = slot_count_ff;
      data_bytes_in = data_bytes_ff;
      count_in      = count_ff;
      push_idx_in   = push_idx_ff;
      pop_idx_in    = pop_idx_ff;
      wo_in         = wo_ff;
      walk_idx_in   = walk_idx_ff;
      walk_left_in  = walk_left_ff;
      chk_vld_in    = chk_vld_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_length_in = rsp_length_ff;
      ram_wr_en     = 1'b0;
      ram_rd_addr   = pop_idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // capture the command word
            if (start) begin
               mode_in  = req_mode;
               tot_in   = {1'b0, req_front_length} + {1'b0, req_body_length};
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (mode_ff == MODE_POP) begin
               if (count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_EMPTY;
                  rsp_offset_in = '0;
                  rsp_length_in = '0;
                  state_in      = ST_IDLE;
               end else begin
                  ram_rd_addr = pop_idx_ff;
                  state_in    = ST_POP;
               end
            end else if (tot_ff > TOT_W'(data_bytes_ff)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_TOO_LARGE;
               rsp_offset_in = '0;
               rsp_length_in = '0;
               state_in      = ST_IDLE;
            end else if (count_ff == slot_count_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_RING_FULL;
               rsp_offset_in = '0;
               rsp_length_in = '0;
               state_in      = ST_IDLE;
            end else begin
               // wrap to the area start; kept even if the walk fails
               if (need_wrap) begin
                  wo_in = '0;
               end
               walk_idx_in  = pop_idx_ff;
               walk_left_in = count_ff;
               chk_vld_in   = 1'b0;
               state_in     = ST_WALK;
            end
         end
         ST_POP: begin
            // hand back the oldest descriptor and free it
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_offset_in = off_out(rd_start);
            rsp_length_in = rd_size;
            pop_idx_in    = slot_next(pop_idx_ff);
            count_in      = count_ff - 1'b1;
            state_in      = ST_IDLE;
         end
         ST_WALK: begin
            if (chk_vld_ff && walk_hit) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NO_SPACE;
               rsp_offset_in = '0;
               rsp_length_in = '0;
               state_in      = ST_IDLE;
            end else if ((walk_left_ff == '0) && !chk_vld_ff) begin
               // no overlap: fill the descriptor and advance
               ram_wr_en     = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_offset_in = off_out(wo_ff);
               rsp_length_in = tot_ff[LEN_W-1:0];
               push_idx_in   = slot_next(push_idx_ff);
               count_in      = count_ff + 1'b1;
               wo_in         = OW'(TOT_W'(wo_ff) + tot_ff);
               state_in      = ST_IDLE;
            end else if (walk_left_ff != '0) begin
               // issue the next descriptor read
               ram_rd_addr  = walk_idx_ff;
               walk_idx_in  = slot_next(walk_idx_ff);
               walk_left_in = walk_left_ff - 1'b1;
               chk_vld_in   = 1'b1;
            end else begin
               chk_vld_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // writes to a defined register clamp the value and clear the queue
      if (csr_wr_en) begin
         if (csr_index == REG_SLOT_COUNT) begin
            if (sc_wr == '0) begin
               slot_count_in = CW'(1);
            end else if (32'(sc_wr) > 32'(MAX_SLOTS)) begin
               slot_count_in = CW'(MAX_SLOTS);
            end else begin
               slot_count_in = CW'(sc_wr);
            end
            count_in    = '0;
            push_idx_in = '0;
            pop_idx_in  = '0;
            wo_in       = '0;
         end else if (csr_index == REG_DATA_BYTES) begin
            if (db_wr == '0) begin
               data_bytes_in = OW'(1);
            end else if (32'(db_wr) > 32'(MAX_DATA_BYTES)) begin
               data_bytes_in = OW'(MAX_DATA_BYTES);
            end else begin
               data_bytes_in = OW'(db_wr);
            end
            count_in    = '0;
            push_idx_in = '0;
            pop_idx_in  = '0;
            wo_in       = '0;
         end
      end
   end

   // drive ports
   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_offset = rsp_offset_ff;
   assign rsp_entry_length = rsp_length_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= slot_count_ff)
      else $error("descriptor count exceeds slot_count");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, push_idx_ff} < {1'b0, CW'(slot_count_ff)}) &&
      ({1'b0, pop_idx_ff} < {1'b0, CW'(slot_count_ff)}))
      else $error("ring index beyond slot_count");

   a_offset_bound: assert property (@(posedge clock) disable iff (reset)
      wo_ff <= data_bytes_ff)
      else $error("write offset beyond data area");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) != ST_IDLE)
      else $error("response without a command in progress");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STATUS_OK)) |->
      ((rsp_offset_ff == '0) && (rsp_length_ff == '0)))
      else $error("failed response carries offset or length");

endmodule

`default_nettype wire

>>> hw/rtl/vlrq_ram.sv
// ----------------------------------------------------------------------------
// vlrq_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module vlrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the variable-length record queue
// Drives push and pop words through the start/busy port, mirrors the
// descriptor ring and data-area bookkeeping in a local predictor, and checks
// every response strobe against the oldest predicted outcome. Phases switch
// the slot count and data-area size, including out-of-range register values.
// ----------------------------------------------------------------------------
module tb_top
   import vlrq_pkg::*;
();

   // register indexes past the defined list; writes to them are dropped
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 2'd3;

   // one command word and the response it should produce
   typedef struct packed {
      logic             mode;
      logic [LEN_W-1:0] front;
      logic [LEN_W-1:0] body;
      logic             drain_first;
   } order_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [OFF_OUT_W-1:0] offset;
      logic [LEN_W-1:0]     length;
   } outcome_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_mode;
   logic [LEN_W-1:0]      req_front_length;
   logic [LEN_W-1:0]      req_body_length;
   logic                  rsp_valid;
   logic [STATUS_W-1:0]   rsp_status;
   logic [OFF_OUT_W-1:0]  rsp_entry_offset;
   logic [LEN_W-1:0]      rsp_entry_length;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // stimulus and expectation stores
   order_type   orders_q[$];
   outcome_type outcome_q[$];
   order_type   live_order;
   int unsigned gap_pct;
   int unsigned mismatches;

   // predictor copy of configuration and ring state
   int unsigned      live_slots;
   logic [LEN_W-1:0] area_bytes;
   logic             desc_busy  [DEF_MAX_SLOTS];
   logic [LEN_W-1:0] desc_start [DEF_MAX_SLOTS];
   logic [LEN_W-1:0] desc_size  [DEF_MAX_SLOTS];
   int unsigned      push_ptr;
   int unsigned      pop_ptr;
   logic [LEN_W-1:0] wr_off;

   variable_length_record_queue dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_front_length (req_front_length),
      .req_body_length  (req_body_length),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_entry_offset (rsp_entry_offset),
      .rsp_entry_length (rsp_entry_length),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // empty the ring and rewind all pointers
   function automatic void clear_ring();
      for (int unsigned i = 0; i < DEF_MAX_SLOTS; i++) begin
         desc_busy[i]  = 1'b0;
         desc_start[i] = '0;
         desc_size[i]  = '0;
      end
      push_ptr = 0;
      pop_ptr  = 0;
      wr_off   = '0;
   endfunction

   function automatic int unsigned step_slot(input int unsigned i);
      return (i + 1 >= live_slots) ? 0 : i + 1;
   endfunction

   // clamp a register write into range; a defined register clears the ring
   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] value);
      int unsigned v;
      case (idx)
         REG_SLOT_COUNT: begin
            v = value[SC_REG_W-1:0];
            live_slots = (v == 0) ? 1 : (v > DEF_MAX_SLOTS) ? DEF_MAX_SLOTS : v;
            clear_ring();
         end
         REG_DATA_BYTES: begin
            v = value;
            area_bytes = (v == 0) ? 1 : (v > DEF_MAX_DATA_BYTES) ? DEF_MAX_DATA_BYTES : v;
            clear_ring();
         end
         default: begin
         end
      endcase
   endfunction

   // work out the response to one word and advance the ring state
   function automatic outcome_type predict_outcome(input order_type o);
      outcome_type      r;
      logic [TOT_W-1:0] total;
      int unsigned      idx;
      int unsigned      k;
      logic             clash;
      r = '0;
      if (push_ptr >= live_slots) push_ptr = 0;
      if (pop_ptr >= live_slots) pop_ptr = 0;
      if (o.mode == MODE_POP) begin
         if (!desc_busy[pop_ptr]) begin
            r.status = STATUS_EMPTY;
         end else begin
            r.status = STATUS_OK;
            r.offset = desc_start[pop_ptr][OFF_OUT_W-1:0];
            r.length = desc_size[pop_ptr];
            desc_busy[pop_ptr] = 1'b0;
            pop_ptr = step_slot(pop_ptr);
         end
         return r;
      end
      total = o.front + o.body;
      if (total > area_bytes) begin
         r.status = STATUS_TOO_LARGE;
         return r;
      end
      if (desc_busy[push_ptr]) begin
         r.status = STATUS_RING_FULL;
         return r;
      end
      // wrap to the start when the tail is too short; the wrap sticks on failure
      if (wr_off > area_bytes || total > area_bytes - wr_off) wr_off = '0;
      // walk queued records from the oldest, looking for one in the way
      idx   = pop_ptr;
      clash = 1'b0;
      for (k = 0; k < live_slots && desc_busy[idx] && !clash; k++) begin
         if (desc_start[idx] >= wr_off && desc_start[idx] - wr_off < total) clash = 1'b1;
         idx = step_slot(idx);
      end
      if (clash) begin
         r.status = STATUS_NO_SPACE;
         return r;
      end
      desc_start[push_ptr] = wr_off;
      desc_size[push_ptr]  = total[LEN_W-1:0];
      desc_busy[push_ptr]  = 1'b1;
      push_ptr = step_slot(push_ptr);
      r.status = STATUS_OK;
      r.offset = wr_off[OFF_OUT_W-1:0];
      r.length = total[LEN_W-1:0];
      wr_off = wr_off + total[LEN_W-1:0];
      return r;
   endfunction

   function automatic void queue_order(input logic mode, input logic [LEN_W-1:0] front,
                                       input logic [LEN_W-1:0] body,
                                       input logic drain_first);
      order_type o;
      o.mode        = mode;
      o.front       = front;
      o.body        = body;
      o.drain_first = drain_first;
      orders_q.push_back(o);
   endfunction

   // random word; a push is sized against the current data area unless left raw
   function automatic order_type make_random_order(input int unsigned pop_pct);
      order_type   o;
      int unsigned pick;
      int unsigned span;
      int unsigned sum;
      o.drain_first = ($urandom_range(0, 99) < 3);
      o.front = $urandom;
      o.body  = $urandom;
      if ($urandom_range(0, 99) < pop_pct) begin
         o.mode = MODE_POP;
         return o;
      end
      o.mode = MODE_PUSH;
      pick = $urandom_range(0, 99);
      if (pick >= 8) begin
         if (pick < 16) begin
            sum = area_bytes - 1 + $urandom_range(0, 2);
         end else begin
            span = area_bytes >> $urandom_range(0, 4);
            sum  = $urandom_range(0, span);
         end
         o.front = $urandom_range(0, sum);
         o.body  = sum - o.front;
      end
      return o;
   endfunction

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40) $display("tb_top: mismatch %0d: %s", mismatches, what);
   endtask

   // wait until every word is taken and answered, then let the tail pass
   task automatic wait_drained(input int unsigned tail);
      @(negedge clock);
      while (orders_q.size() != 0 || start || outcome_q.size() != 0) @(negedge clock);
      repeat (tail) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      apply_register(idx, value);
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_phase(input int unsigned count, input int unsigned idle_pct);
      int unsigned pop_pct;
      gap_pct = idle_pct;
      pop_pct = 40;
      for (int unsigned n = 0; n < count; n++) begin
         if (n % 32 == 0) pop_pct = $urandom_range(15, 70);
         orders_q.push_back(make_random_order(pop_pct));
      end
      wait_drained(4);
   endtask

   // driver: present the next word when the port is free, hold it while busy
   always @(posedge clock) begin
      logic accepted;
      logic drained;
      if (reset) begin
         start <= 1'b0;
      end else begin
         accepted = start && !busy;
         if (accepted) outcome_q.push_back(predict_outcome(live_order));
         if (!start || accepted) begin
            // count a strobe in this cycle as answered, whichever block runs first
            drained = !accepted &&
                      (outcome_q.size() == 0 || (outcome_q.size() == 1 && rsp_valid));
            if (orders_q.size() != 0 && $urandom_range(0, 99) >= gap_pct &&
                (!orders_q[0].drain_first || drained)) begin
               live_order = orders_q.pop_front();
               start            <= 1'b1;
               req_mode         <= live_order.mode;
               req_front_length <= live_order.front;
               req_body_length  <= live_order.body;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each response strobe with the oldest prediction
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid) begin
         if (outcome_q.size() == 0) begin
            note_mismatch($sformatf("response with nothing pending, status %0d",
                                    rsp_status));
         end else begin
            want = outcome_q.pop_front();
            if (rsp_status !== want.status)
               note_mismatch($sformatf("status got %0d want %0d", rsp_status, want.status));
            if (rsp_entry_offset !== want.offset)
               note_mismatch($sformatf("entry_offset got %0d want %0d",
                                       rsp_entry_offset, want.offset));
            if (rsp_entry_length !== want.length)
               note_mismatch($sformatf("entry_length got %0d want %0d",
                                       rsp_entry_length, want.length));
         end
      end
   end

   initial begin
      #30000000;
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      live_slots       = DEF_MAX_SLOTS;
      area_bytes       = DEF_MAX_DATA_BYTES;
      clear_ring();
      mismatches       = 0;
      gap_pct          = 0;
      reset            = 1'b1;
      start            = 1'b0;
      req_mode         = MODE_PUSH;
      req_front_length = '0;
      req_body_length  = '0;
      csr_wr_en        = 1'b0;
      csr_index        = REG_SLOT_COUNT;
      csr_wdata        = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset sizes: oversize, exact fit, zero length at the end, sticky wrap
      queue_order(MODE_POP,  0, 0, 1'b0);
      queue_order(MODE_PUSH, 17'h1FFFF, 17'h1FFFF, 1'b0);
      queue_order(MODE_PUSH, 65536, 1, 1'b0);
      queue_order(MODE_PUSH, 0, 65536, 1'b0);
      queue_order(MODE_PUSH, 0, 0, 1'b0);
      queue_order(MODE_PUSH, 10, 5, 1'b0);
      queue_order(MODE_POP,  17'h1FFFF, 17'h1FFFF, 1'b0);
      queue_order(MODE_POP,  0, 0, 1'b0);
      queue_order(MODE_POP,  0, 0, 1'b0);
      queue_order(MODE_PUSH, 65535, 0, 1'b0);
      queue_order(MODE_PUSH, 1, 0, 1'b1);
      queue_order(MODE_PUSH, 1, 0, 1'b0);
      queue_order(MODE_POP,  0, 0, 1'b0);
      queue_order(MODE_POP,  0, 0, 1'b0);
      run_phase(200, 0);

      // two slots over sixteen bytes: ring full, reuse after pop, wrap to zero
      write_register(REG_SLOT_COUNT, 2);
      write_register(REG_DATA_BYTES, 16);
      end_writes();
      queue_order(MODE_PUSH, 4, 0, 1'b0);
      queue_order(MODE_PUSH, 0, 4, 1'b0);
      queue_order(MODE_PUSH, 2, 2, 1'b0);
      queue_order(MODE_POP,  0, 0, 1'b0);
      queue_order(MODE_PUSH, 8, 0, 1'b0);
      queue_order(MODE_PUSH, 1, 0, 1'b0);
      queue_order(MODE_POP,  0, 0, 1'b0);
      queue_order(MODE_PUSH, 3, 1, 1'b0);
      queue_order(MODE_PUSH, 16, 1, 1'b0);
      queue_order(MODE_POP,  0, 0, 1'b0);
      queue_order(MODE_POP,  0, 0, 1'b0);
      queue_order(MODE_POP,  0, 0, 1'b0);
      run_phase(150, 63);

      // zero in both registers rounds up to one
      write_register(REG_SLOT_COUNT, 0);
      write_register(REG_DATA_BYTES, 0);
      end_writes();
      run_phase(100, 0);

      // all-ones values saturate to the largest sizes
      write_register(REG_SLOT_COUNT, 127);
      write_register(REG_DATA_BYTES, 17'h1FFFF);
      end_writes();
      run_phase(250, 21);

      // spare indexes are dropped and must leave the queue as it stands
      write_register(REG_SPARE_A, $urandom);
      write_register(REG_SPARE_B, $urandom);
      end_writes();
      run_phase(100, 0);

      write_register(REG_SLOT_COUNT, 1);
      write_register(REG_DATA_BYTES, 65536);
      end_writes();
      run_phase(100, 63);

      write_register(REG_SLOT_COUNT, 64);
      write_register(REG_DATA_BYTES, 1);
      end_writes();
      run_phase(100, 0);

      write_register(REG_SLOT_COUNT, 5);
      write_register(REG_DATA_BYTES, 100);
      end_writes();
      run_phase(200, 21);

      write_register(REG_DATA_BYTES, 4096);
      end_writes();
      run_phase(200, 63);

      write_register(REG_SLOT_COUNT, 65);
      write_register(REG_DATA_BYTES, 1000);
      end_writes();
      run_phase(250, 0);

      for (int unsigned p = 0; p < 3; p++) begin
         write_register(REG_SLOT_COUNT, $urandom_range(1, 64));
         write_register(REG_DATA_BYTES, $urandom_range(1, 70000));
         end_writes();
         run_phase(100, (p == 1) ? 63 : 21);
      end

      // let any stray strobe show up before the verdict
      wait_drained(72);
      if (mismatches == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
